// ----- hdl/hptd_pkg.sv -----
package hptd_pkg;

  localparam int unsigned HEADING_W  = 13;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned BAND_W     = 12;
  localparam int unsigned SHAPE_W    = 7;
  localparam int unsigned DRIVE_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP    = 3'd0,
    CFG_GAIN_INTEG   = 3'd1,
    CFG_GAIN_DERIV   = 3'd2,
    CFG_INTEG_BAND   = 3'd3,
    CFG_DEAD_BAND    = 3'd4,
    CFG_BOOST_BELOW  = 3'd5,
    CFG_BOOST_VALUE  = 3'd6,
    CFG_OUTPUT_LIMIT = 3'd7
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0]  RST_GAIN_PROP    = 16'd205;
  localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG   = 16'd901;
  localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV   = 16'd287;
  localparam logic [BAND_W-1:0]  RST_INTEG_BAND   = 12'd10;
  localparam logic [SHAPE_W-1:0] RST_DEAD_BAND    = 7'd5;
  localparam logic [SHAPE_W-1:0] RST_BOOST_BELOW  = 7'd19;
  localparam logic [SHAPE_W-1:0] RST_BOOST_VALUE  = 7'd21;
  localparam logic [SHAPE_W-1:0] RST_OUTPUT_LIMIT = 7'd127;

endpackage

// ----- hdl/heading_pid_turn_drive_core.sv -----
// heading-hold pid turn drive
// s_axis carries one gyro heading sample per transaction (tdata[12:0], signed,
// upper bits zero); the target heading is zero. m_axis returns one drive pair
// per transaction: tdata[7:0] left drive, tdata[15:8] right drive, both signed,
// opposite in sign so the robot turns in place.
// the cfg port writes gain, band and shaping registers by index, one per
// cycle while cfg_we_i is high; write only while no transaction is in flight.
// pipeline: four register stages (error/integral/derivative update, the three
// gain products, their sum, truncation and shaping). one sample per cycle is
// sustained while m_axis_tready is high; the integral and previous-error
// update is registered at acceptance.
// when m_axis_tready is low the stages fill up one by one and s_axis_tready
// drops only once every stage holds a result; nothing is lost or repeated.
// reset clears the integral, the previous error and all valid flags and
// reloads the default register values.
module heading_pid_turn_drive_core
  import hptd_pkg::*;
#(
  parameter int unsigned GAIN_FRAC_BITS = 12,
  parameter int unsigned INTEG_BITS     = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [12:0] heading
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [7:0] left_drive, [15:8] right_drive
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DERIV_W  = HEADING_W + 1;
  localparam int unsigned PP_W     = GAIN_W + 1 + HEADING_W;
  localparam int unsigned PI_W     = GAIN_W + 1 + INTEG_BITS;
  localparam int unsigned PD_W     = GAIN_W + 1 + DERIV_W;
  localparam int unsigned ACC_W    = INTEG_BITS + GAIN_W + 3;
  localparam int unsigned CMD_W    = ACC_W - GAIN_FRAC_BITS;
  localparam int unsigned ISUM_W   = INTEG_BITS + 1;

  // registers
  logic [GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [BAND_W-1:0]  integ_band_q;
  logic [SHAPE_W-1:0] dead_band_q, boost_below_q, boost_value_q, output_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q    <= RST_GAIN_PROP;
      gain_integ_q   <= RST_GAIN_INTEG;
      gain_deriv_q   <= RST_GAIN_DERIV;
      integ_band_q   <= RST_INTEG_BAND;
      dead_band_q    <= RST_DEAD_BAND;
      boost_below_q  <= RST_BOOST_BELOW;
      boost_value_q  <= RST_BOOST_VALUE;
      output_limit_q <= RST_OUTPUT_LIMIT;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN_PROP:    gain_prop_q    <= cfg_data_i;
        CFG_GAIN_INTEG:   gain_integ_q   <= cfg_data_i;
        CFG_GAIN_DERIV:   gain_deriv_q   <= cfg_data_i;
        CFG_INTEG_BAND:   integ_band_q   <= cfg_data_i[BAND_W-1:0];
        CFG_DEAD_BAND:    dead_band_q    <= cfg_data_i[SHAPE_W-1:0];
        CFG_BOOST_BELOW:  boost_below_q  <= cfg_data_i[SHAPE_W-1:0];
        CFG_BOOST_VALUE:  boost_value_q  <= cfg_data_i[SHAPE_W-1:0];
        CFG_OUTPUT_LIMIT: output_limit_q <= cfg_data_i[SHAPE_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic v1_q, v2_q, v3_q, vo_q;
  logic rdy1, rdy2, rdy3, rdyo;

  assign rdyo = !vo_q || m_axis_tready;
  assign rdy3 = !v3_q || rdyo;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  logic acc_in;
  assign acc_in = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdyo) vo_q <= v3_q;
    end
  end

  // stage 1: error, integral and derivative; err_q doubles as previous error
  logic signed [HEADING_W-1:0] heading, err_d, err_q;
  logic        [BAND_W-1:0]    mag;
  logic signed [INTEG_BITS-1:0] integ_d, integ_q;
  logic signed [ISUM_W-1:0]     isum;
  logic signed [DERIV_W-1:0]    deriv_d, deriv_q;

  assign heading = signed'(s_axis_tdata[HEADING_W-1:0]);

  always_comb begin
    if (heading == {1'b1, {(HEADING_W-1){1'b0}}}) begin
      err_d = {1'b0, {(HEADING_W-1){1'b1}}};
    end else begin
      err_d = -heading;
    end
    mag = err_d[HEADING_W-1] ? BAND_W'(-err_d) : BAND_W'(err_d);
    isum = ISUM_W'(integ_q) + ISUM_W'(err_d);
    if (err_d == '0 || mag > integ_band_q) begin
      integ_d = '0;
    end else if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integ_d = isum[ISUM_W-1] ? {1'b1, {(INTEG_BITS-1){1'b0}}}
                               : {1'b0, {(INTEG_BITS-1){1'b1}}};
    end else begin
      integ_d = isum[INTEG_BITS-1:0];
    end
    deriv_d = DERIV_W'(err_d) - DERIV_W'(err_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q   <= '0;
      integ_q <= '0;
    end else if (acc_in) begin
      err_q   <= err_d;
      integ_q <= integ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) deriv_q <= deriv_d;
  end

  // stage 2: gain products
  logic signed [PP_W-1:0] pp_d, pp_q;
  logic signed [PI_W-1:0] pi_d, pi_q;
  logic signed [PD_W-1:0] pd_d, pd_q;

  assign pp_d = $signed({1'b0, gain_prop_q})  * err_q;
  assign pi_d = $signed({1'b0, gain_integ_q}) * integ_q;
  assign pd_d = $signed({1'b0, gain_deriv_q}) * deriv_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      pp_q <= pp_d;
      pi_q <= pi_d;
      pd_q <= pd_d;
    end
  end

  // stage 3: sum
  logic signed [ACC_W-1:0] acc_d, acc_q;

  assign acc_d = ACC_W'(pp_q) + ACC_W'(pi_q) + ACC_W'(pd_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) acc_q <= acc_d;
  end

  // stage 4: truncate toward zero and shape
  logic signed [ACC_W-1:0]   acc_adj;
  logic signed [CMD_W-1:0]   cmd, db_s, lim_s, bb_s, bv_s, shaped;
  logic signed [DRIVE_W-1:0] right_d, left_d;
  logic [M_TDATA_W-1:0]      tdata_q;

  always_comb begin
    acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'((1 << GAIN_FRAC_BITS) - 1) : '0);
    cmd     = acc_adj[ACC_W-1:GAIN_FRAC_BITS];
    db_s    = signed'(CMD_W'(dead_band_q));
    lim_s   = signed'(CMD_W'(output_limit_q));
    bb_s    = signed'(CMD_W'(boost_below_q));
    bv_s    = signed'(CMD_W'(boost_value_q));
    if (cmd > -db_s && cmd < db_s) begin
      shaped = '0;
    end else if (cmd > lim_s) begin
      shaped = lim_s;
    end else if (cmd < -lim_s) begin
      shaped = -lim_s;
    end else if (cmd > 0 && cmd < bb_s) begin
      shaped = bv_s;
    end else if (cmd < 0 && cmd > -bb_s) begin
      shaped = -bv_s;
    end else begin
      shaped = cmd;
    end
    right_d = shaped[DRIVE_W-1:0];
    left_d  = -right_d;
  end

  always_ff @(posedge clk_i) begin
    if (rdyo && v3_q) tdata_q <= {right_d, left_d};
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = tdata_q;

endmodule
